@@ src/lsi_pkg.sv @@
// Shared types and constants for the line segment intersection pipeline.
// No dependencies; every other file imports this package.
package lsi_pkg;

  // Coordinate width and the derived datapath widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;       // endpoint differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;        // signed cross terms
  localparam int DEN_BITS   = 2 * COORD_BITS + 1;   // |den|, and tn when in range
  localparam int LO_BITS    = COORD_BITS + 1;       // low slice of tn for partials
  localparam int HI_BITS    = DEN_BITS - LO_BITS;   // high slice of tn
  localparam int DVD_BITS   = DEN_BITS + COORD_BITS; // tn * |b|
  localparam int RES_BITS   = COORD_BITS + 2;       // final point arithmetic

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_PAR   = 2'd1,
    ST_OUT_T = 2'd2,
    ST_OUT_U = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } in_item_t;

  typedef struct packed {
    status_t                      status;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } out_item_t;

  // Front end result: sign-normalized den, tn, un and the segment one terms
  typedef struct packed {
    logic signed [PROD_BITS-1:0]  den;
    logic signed [PROD_BITS-1:0]  tn;
    logic signed [PROD_BITS-1:0]  un;
    logic                         par;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0]        bx_mag;
    logic [COORD_BITS-1:0]        by_mag;
    logic                         bx_neg;
    logic                         by_neg;
  } front_t;

  // Sideband that rides alongside the dividers
  typedef struct packed {
    status_t                      status;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic                         bx_neg;
    logic                         by_neg;
  } side_t;

endpackage

@@ src/lsi_front.sv @@
// Front end: differences, cross products, den/tn/un and sign normalization.
// Four register stages. Depends on lsi_pkg.
module lsi_front import lsi_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  in_item_t din,
  output front_t   dout
);

  logic signed [DIFF_BITS-1:0]  bx1_r, by1_r, dx1_r, dy1_r, cx1_r, cy1_r;
  logic signed [COORD_BITS-1:0] ax1_r, ay1_r;
  logic signed [PROD_BITS-1:0]  bd2_r, bdx2_r, cd2_r, cdx2_r, cb2_r, cbx2_r;
  logic signed [DIFF_BITS-1:0]  bx2_r, by2_r;
  logic signed [COORD_BITS-1:0] ax2_r, ay2_r;
  logic signed [PROD_BITS-1:0]  den3_r, tn3_r, un3_r;
  logic signed [DIFF_BITS-1:0]  bx3_r, by3_r;
  logic signed [COORD_BITS-1:0] ax3_r, ay3_r;
  logic signed [DIFF_BITS-1:0]  bx_abs, by_abs;
  front_t                       dout_r;
  logic                         neg;

  // Stage 1: direction and offset vectors
  always_ff @(posedge clk) begin
    if (en) begin
      bx1_r <= {din.first_end_x[COORD_BITS-1], din.first_end_x}
             - {din.first_start_x[COORD_BITS-1], din.first_start_x};
      by1_r <= {din.first_end_y[COORD_BITS-1], din.first_end_y}
             - {din.first_start_y[COORD_BITS-1], din.first_start_y};
      dx1_r <= {din.second_end_x[COORD_BITS-1], din.second_end_x}
             - {din.second_start_x[COORD_BITS-1], din.second_start_x};
      dy1_r <= {din.second_end_y[COORD_BITS-1], din.second_end_y}
             - {din.second_start_y[COORD_BITS-1], din.second_start_y};
      cx1_r <= {din.second_start_x[COORD_BITS-1], din.second_start_x}
             - {din.first_start_x[COORD_BITS-1], din.first_start_x};
      cy1_r <= {din.second_start_y[COORD_BITS-1], din.second_start_y}
             - {din.first_start_y[COORD_BITS-1], din.first_start_y};
      ax1_r <= din.first_start_x;
      ay1_r <= din.first_start_y;
    end
  end

  // Stage 2: six cross terms
  always_ff @(posedge clk) begin
    if (en) begin
      bd2_r  <= bx1_r * dy1_r;
      bdx2_r <= by1_r * dx1_r;
      cd2_r  <= cx1_r * dy1_r;
      cdx2_r <= cy1_r * dx1_r;
      cb2_r  <= cx1_r * by1_r;
      cbx2_r <= cy1_r * bx1_r;
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
    end
  end

  // Stage 3: determinant and parameter numerators
  always_ff @(posedge clk) begin
    if (en) begin
      den3_r <= bd2_r - bdx2_r;
      tn3_r  <= cd2_r - cdx2_r;
      un3_r  <= cb2_r - cbx2_r;
      bx3_r  <= bx2_r;
      by3_r  <= by2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
    end
  end

  // Stage 4: make den positive, take |b| per axis
  assign neg    = den3_r[PROD_BITS-1];
  assign bx_abs = bx3_r[DIFF_BITS-1] ? -bx3_r : bx3_r;
  assign by_abs = by3_r[DIFF_BITS-1] ? -by3_r : by3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r.den    <= neg ? -den3_r : den3_r;
      dout_r.tn     <= neg ? -tn3_r : tn3_r;
      dout_r.un     <= neg ? -un3_r : un3_r;
      dout_r.par    <= (den3_r == '0);
      dout_r.ax     <= ax3_r;
      dout_r.ay     <= ay3_r;
      dout_r.bx_mag <= bx_abs[COORD_BITS-1:0];
      dout_r.by_mag <= by_abs[COORD_BITS-1:0];
      dout_r.bx_neg <= bx3_r[DIFF_BITS-1];
      dout_r.by_neg <= by3_r[DIFF_BITS-1];
    end
  end

  assign dout = dout_r;

endmodule

@@ src/lsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Quotient is known to fit COORD_BITS. Depends on lsi_pkg.
module lsi_div import lsi_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DVD_BITS-1:0]   dvd,
  input  logic [DEN_BITS-1:0]   den,
  output logic [COORD_BITS-1:0] quot,
  output logic                  frac
);

  logic [DEN_BITS-1:0]   rem_r [COORD_BITS];
  logic [DEN_BITS-1:0]   den_r [COORD_BITS];
  logic [COORD_BITS-1:0] lo_r  [COORD_BITS];
  logic [COORD_BITS-1:0] q_r   [COORD_BITS];

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
    logic [DEN_BITS:0]     trial;
    logic [DEN_BITS:0]     diff;
    logic [DEN_BITS-1:0]   den_in;
    logic [COORD_BITS-1:0] lo_in;
    logic [COORD_BITS-1:0] q_in;
    logic                  ge;

    // Stage inputs: first stage takes the upper dividend as partial remainder
    if (k == 0) begin : g_first
      assign trial  = {dvd[DVD_BITS-1:COORD_BITS], dvd[COORD_BITS-1]};
      assign den_in = den;
      assign lo_in  = dvd[COORD_BITS-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign trial  = {rem_r[k-1], lo_r[k-1][COORD_BITS-1]};
      assign den_in = den_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign diff = trial - {1'b0, den_in};
    assign ge   = ~diff[DEN_BITS];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        den_r[k] <= den_in;
        lo_r[k]  <= {lo_in[COORD_BITS-2:0], 1'b0};
        q_r[k]   <= {q_in[COORD_BITS-2:0], ge};
      end
    end
  end

  assign quot = q_r[COORD_BITS-1];
  assign frac = (rem_r[COORD_BITS-1] != '0);

endmodule

@@ src/line_segment_intersection.sv @@
// Top level of the segment intersection pipeline: front end, range checks,
// partial products, two dividers and the rounding/output stage.
// Depends on lsi_pkg, lsi_front and lsi_div.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------
//   in      | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out     | output    | out_valid/out_stall| out_data (out_item_t)
//
// One segment pair enters per cycle while in_stall is low; the pipeline is
// 4 front end stages, check/partial product, product sum, one divider
// stage per quotient bit, and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output freezes the whole pipeline while the output
// register holds a transfer, and in_stall follows it.
module line_segment_intersection import lsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int DEPTH = COORD_BITS + 6;

  logic                        adv;
  logic [DEPTH-1:0]            vld_r;
  front_t                      fr;
  logic                        t_bad, u_bad;
  status_t                     st;
  logic [LO_BITS+COORD_BITS-1:0] pxl5_r, pyl5_r;
  logic [HI_BITS+COORD_BITS-1:0] pxh5_r, pyh5_r;
  logic [DEN_BITS-1:0]         den5_r, den6_r;
  side_t                       side5_r, side6_r;
  logic [DVD_BITS-1:0]         nx6_r, ny6_r;
  side_t                       side_r [COORD_BITS];
  logic [COORD_BITS-1:0]       qx, qy;
  logic                        fx, fy;
  logic signed [RES_BITS-1:0]  rx, ry, rx_t, ry_t;
  logic                        out_valid_r;
  out_item_t                   out_r;

  // Whole pipeline advances unless the output holds a stalled transfer
  assign adv      = ~(out_valid_r & out_stall);
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  lsi_front u_front (
    .clk  (clk),
    .en   (adv),
    .din  (in_data),
    .dout (fr)
  );

  // Stage 5: range checks and partial products of tn * |b|
  assign t_bad = fr.tn[PROD_BITS-1] || (fr.tn > fr.den);
  assign u_bad = fr.un[PROD_BITS-1] || (fr.un > fr.den);

  always_comb begin
    if (fr.par)      st = ST_PAR;
    else if (t_bad)  st = ST_OUT_T;
    else if (u_bad)  st = ST_OUT_U;
    else             st = ST_HIT;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxl5_r <= fr.tn[LO_BITS-1:0] * fr.bx_mag;
      pxh5_r <= fr.tn[DEN_BITS-1:LO_BITS] * fr.bx_mag;
      pyl5_r <= fr.tn[LO_BITS-1:0] * fr.by_mag;
      pyh5_r <= fr.tn[DEN_BITS-1:LO_BITS] * fr.by_mag;
      den5_r <= fr.den[DEN_BITS-1:0];
      side5_r.status <= st;
      side5_r.ax     <= fr.ax;
      side5_r.ay     <= fr.ay;
      side5_r.bx_neg <= fr.bx_neg;
      side5_r.by_neg <= fr.by_neg;
    end
  end

  // Stage 6: combine partial products into the dividends
  always_ff @(posedge clk) begin
    if (adv) begin
      nx6_r   <= DVD_BITS'(pxl5_r) + (DVD_BITS'(pxh5_r) << LO_BITS);
      ny6_r   <= DVD_BITS'(pyl5_r) + (DVD_BITS'(pyh5_r) << LO_BITS);
      den6_r  <= den5_r;
      side6_r <= side5_r;
    end
  end

  lsi_div u_div_x (
    .clk  (clk),
    .en   (adv),
    .dvd  (nx6_r),
    .den  (den6_r),
    .quot (qx),
    .frac (fx)
  );

  lsi_div u_div_y (
    .clk  (clk),
    .en   (adv),
    .dvd  (ny6_r),
    .den  (den6_r),
    .quot (qy),
    .frac (fy)
  );

  // Sideband delay matching the divider depth
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side6_r;
      for (int k = 1; k < COORD_BITS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Floor of s + q*sign(b), then move toward zero when a fraction remains
  always_comb begin
    if (side_r[COORD_BITS-1].bx_neg) begin
      rx = RES_BITS'(side_r[COORD_BITS-1].ax) - RES_BITS'(qx) - RES_BITS'(fx);
    end else begin
      rx = RES_BITS'(side_r[COORD_BITS-1].ax) + RES_BITS'(qx);
    end
    if (side_r[COORD_BITS-1].by_neg) begin
      ry = RES_BITS'(side_r[COORD_BITS-1].ay) - RES_BITS'(qy) - RES_BITS'(fy);
    end else begin
      ry = RES_BITS'(side_r[COORD_BITS-1].ay) + RES_BITS'(qy);
    end
    rx_t = (rx[RES_BITS-1] && fx) ? rx + RES_BITS'(1) : rx;
    ry_t = (ry[RES_BITS-1] && fy) ? ry + RES_BITS'(1) : ry;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.status <= side_r[COORD_BITS-1].status;
      if (side_r[COORD_BITS-1].status == ST_HIT) begin
        out_r.cross_x <= rx_t[COORD_BITS-1:0];
        out_r.cross_y <= ry_t[COORD_BITS-1:0];
      end else begin
        out_r.cross_x <= '0;
        out_r.cross_y <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
